// ===== rtl/mfsr_pkg.sv =====
package mfsr_pkg;

   // framebuffer geometry
   localparam int WIDTH       = 128;
   localparam int HEIGHT      = 64;
   localparam int FRAME_BYTES = 1024;

   localparam int ROW_BYTES = WIDTH / 8;
   localparam int ROWS      = FRAME_BYTES / ROW_BYTES;
   localparam int ROW_W     = $clog2(ROWS);
   localparam int SEG_W     = $clog2(HEIGHT);
   localparam int BIT_W     = $clog2(WIDTH);
   localparam int BYTE_W    = $clog2(ROW_BYTES);

   // item fields
   localparam int FUNC_W = 2;
   localparam int COL_W  = 7;
   localparam int ROWF_W = 6;

   // configuration port
   localparam int CSR_W     = 7;
   localparam int CSR_IDX_W = 1;

   // segment layout: two 3-byte commands, data start byte, two nibbles per row byte
   localparam int CMD_BYTES  = 3;
   localparam int DATA_FIRST = 2 * CMD_BYTES + 1;
   localparam int SEG_BYTES  = DATA_FIRST + 2 * ROW_BYTES;
   localparam int CNT_W      = $clog2(SEG_BYTES);

   localparam logic [7:0] START_CMD   = 8'hF8;
   localparam logic [7:0] START_DATA  = 8'hFA;
   localparam logic [7:0] ADDR_FLAG   = 8'h80;
   localparam logic [7:0] NIBBLE_MASK = 8'hF0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SET_PIXEL = 2'd0,
      FUNC_CLEAR     = 2'd1,
      FUNC_REFRESH   = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_COLUMN = 1'b0,
      CSR_MAX_ROW    = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PIX_MODIFY,
      ST_SEG_EMIT
   } state_type;

   typedef struct packed {
      logic             rd_en;
      logic             rd_seg;
      logic             wr_en;
      logic             clear_all;
      logic             out_load;
      logic             seg_advance;
      logic [CNT_W-1:0] byte_cnt;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/mfsr_if.sv =====
interface mfsr_req_if;
   logic                        valid;
   logic                        ready;
   logic [mfsr_pkg::FUNC_W-1:0] func;
   logic [mfsr_pkg::COL_W-1:0]  col;
   logic [mfsr_pkg::ROWF_W-1:0] row;

   modport source (output valid, output func, output col, output row, input ready);
   modport sink   (input valid, input func, input col, input row, output ready);
endinterface

interface mfsr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] spi_byte;
   logic       transfer_end;
   logic       last;

   modport source (output valid, output spi_byte, output transfer_end, output last,
                   input ready);
   modport sink   (input valid, input spi_byte, input transfer_end, input last,
                   output ready);
endinterface

// ===== rtl/mono_framebuffer_serial_refresh.sv =====
// One-bit 128x64 framebuffer with a serial display refresh stream. Set-pixel
// items read the row and then write it back, a clear is done on acceptance and
// a refresh item reads the frame row, then sends 39 bytes at one per cycle
// through the output register while the sink does not stall. The store is a
// 64-row by 128-bit memory with one read and one write port; a valid bit per
// row makes reset and clear immediate, so no clearing pass is needed. Items are
// worked one at a time.
module mono_framebuffer_serial_refresh (
   input  logic                           clock,
   input  logic                           reset,
   mfsr_req_if.sink                       req_ch,
   mfsr_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [mfsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mfsr_pkg::CSR_W-1:0]     csr_wdata
);
   import mfsr_pkg::*;

   cmd_type    cmd;
   status_type status;

   mfsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mfsr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_col          (req_ch.col),
      .req_row          (req_ch.row),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_spi_byte     (rsp_ch.spi_byte),
      .rsp_transfer_end (rsp_ch.transfer_end),
      .rsp_last         (rsp_ch.last)
   );

`ifndef SYNTHESIS
   a_no_rd_wr_collide: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd_en && cmd.wr_en))
      else $error("memory read and write issued together");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("output register overwritten before transfer");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && cmd.byte_cnt == CNT_W'(SEG_BYTES - 1)) |=> req_ch.ready)
      else $error("controller not idle after final segment byte");

   a_clear_on_transfer: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_all |-> (req_ch.valid && req_ch.ready))
      else $error("clear issued without an input transfer");
`endif

endmodule

// ===== rtl/mfsr_datapath.sv =====
module mfsr_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [mfsr_pkg::COL_W-1:0]     req_col,
   input  logic [mfsr_pkg::ROWF_W-1:0]    req_row,
   input  logic                           csr_we,
   input  logic [mfsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mfsr_pkg::CSR_W-1:0]     csr_wdata,
   input  mfsr_pkg::cmd_type              cmd,
   output mfsr_pkg::status_type           status,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [7:0]                     rsp_spi_byte,
   output logic                           rsp_transfer_end,
   output logic                           rsp_last
);
   import mfsr_pkg::*;

   localparam logic [CNT_W-1:0] CNT_CMD0_START = CNT_W'(0);
   localparam logic [CNT_W-1:0] CNT_CMD0_HI    = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_CMD0_LO    = CNT_W'(2);
   localparam logic [CNT_W-1:0] CNT_CMD1_START = CNT_W'(3);
   localparam logic [CNT_W-1:0] CNT_CMD1_HI    = CNT_W'(4);
   localparam logic [CNT_W-1:0] CNT_CMD1_LO    = CNT_W'(5);
   localparam logic [CNT_W-1:0] CNT_DATA_START = CNT_W'(6);
   localparam logic [CNT_W-1:0] CNT_LAST       = CNT_W'(SEG_BYTES - 1);

   logic [COL_W-1:0]  max_col_ff, max_col_in;
   logic [ROWF_W-1:0] max_row_ff, max_row_in;
   logic [SEG_W-1:0]  seg_ff, seg_in;
   logic [ROWS-1:0]   row_valid_ff, row_valid_in;

   logic [WIDTH-1:0]  mem_ff [ROWS];
   logic [WIDTH-1:0]  rd_data_ff;
   logic              rd_valid_ff;
   logic [COL_W-1:0]  pix_col_ff;
   logic [ROW_W-1:0]  pix_row_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        spi_byte_ff;
   logic              transfer_end_ff;
   logic              last_ff;

   logic [SEG_W-2:0]  seg_y;
   logic              seg_h;
   logic [ROW_W-1:0]  rd_addr;
   logic [WIDTH-1:0]  row_data;
   logic [WIDTH-1:0]  wr_data;
   logic [BIT_W-1:0]  bit_pos;
   logic [7:0]        addr_row;
   logic [7:0]        addr_col;
   logic [CNT_W-1:0]  data_off;
   logic [BYTE_W-1:0] byte_idx;
   logic [7:0]        row_byte;
   logic [7:0]        next_byte;
   logic              next_tend;

   assign seg_y   = seg_ff[SEG_W-1:1];
   assign seg_h   = seg_ff[0];
   assign rd_addr = cmd.rd_seg
      ? ROW_W'(seg_y) + (seg_h ? ROW_W'(HEIGHT / 2) : ROW_W'(0))
      : ROW_W'(req_row);

   assign status.in_range = (req_col <= max_col_ff) && (req_row <= max_row_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // rows never written since the last clear read as zero
   assign row_data = rd_valid_ff ? rd_data_ff : '0;
   assign bit_pos  = BIT_W'(pix_col_ff) ^ BIT_W'(7);
   assign wr_data  = row_data | (WIDTH'(1) << bit_pos);

   always_comb begin
      max_col_in = max_col_ff;
      max_row_in = max_row_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_COLUMN: max_col_in = COL_W'(csr_wdata);
            CSR_MAX_ROW:    max_row_in = ROWF_W'(csr_wdata);
            default:        ;
         endcase
      end
   end

   always_comb begin
      seg_in = seg_ff;
      if (cmd.seg_advance) begin
         seg_in = (seg_ff == SEG_W'(HEIGHT - 1)) ? '0 : seg_ff + SEG_W'(1);
      end
   end

   always_comb begin
      row_valid_in = row_valid_ff;
      if (cmd.clear_all) begin
         row_valid_in = '0;
      end else if (cmd.wr_en) begin
         row_valid_in[pix_row_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_col_ff   <= COL_W'(WIDTH - 1);
         max_row_ff   <= ROWF_W'(HEIGHT - 1);
         seg_ff       <= '0;
         row_valid_ff <= '0;
      end else begin
         max_col_ff   <= max_col_in;
         max_row_ff   <= max_row_in;
         seg_ff       <= seg_in;
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[pix_row_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff  <= mem_ff[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
         pix_col_ff  <= req_col;
         pix_row_ff  <= rd_addr;
      end
   end

   // byte stream of one refresh segment
   assign addr_row = ADDR_FLAG | 8'(seg_y);
   assign addr_col = ADDR_FLAG | (seg_h ? 8'(WIDTH / 16) : 8'h00);
   assign data_off = cmd.byte_cnt - CNT_W'(DATA_FIRST);
   assign byte_idx = data_off[BYTE_W:1];
   assign row_byte = row_data[8 * byte_idx +: 8];

   always_comb begin
      next_tend = 1'b0;
      priority case (cmd.byte_cnt)
         CNT_CMD0_START, CNT_CMD1_START: next_byte = START_CMD;
         CNT_CMD0_HI:    next_byte = addr_row & NIBBLE_MASK;
         CNT_CMD0_LO: begin
            next_byte = {addr_row[3:0], 4'h0};
            next_tend = 1'b1;
         end
         CNT_CMD1_HI:    next_byte = addr_col & NIBBLE_MASK;
         CNT_CMD1_LO: begin
            next_byte = {addr_col[3:0], 4'h0};
            next_tend = 1'b1;
         end
         CNT_DATA_START: next_byte = START_DATA;
         default: begin
            next_byte = data_off[0] ? {row_byte[3:0], 4'h0} : (row_byte & NIBBLE_MASK);
            next_tend = (cmd.byte_cnt == CNT_LAST);
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         spi_byte_ff     <= next_byte;
         transfer_end_ff <= next_tend;
         last_ff         <= (cmd.byte_cnt == CNT_LAST);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_spi_byte     = spi_byte_ff;
   assign rsp_transfer_end = transfer_end_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== rtl/mfsr_ctrl.sv =====
module mfsr_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [mfsr_pkg::FUNC_W-1:0] req_func,
   output logic                        req_ready,
   input  mfsr_pkg::status_type        status,
   output mfsr_pkg::cmd_type           cmd
);
   import mfsr_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.byte_cnt  = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (func_type'(req_func))
                  FUNC_SET_PIXEL: begin
                     // drop pixels outside the configured window
                     if (status.in_range) begin
                        cmd.rd_en = 1'b1;
                        state_in  = ST_PIX_MODIFY;
                     end
                  end
                  FUNC_CLEAR: cmd.clear_all = 1'b1;
                  FUNC_REFRESH: begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_seg = 1'b1;
                     cnt_in     = '0;
                     state_in   = ST_SEG_EMIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_PIX_MODIFY: begin
            cmd.wr_en = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SEG_EMIT: begin
            // advance one byte whenever the output register frees up
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (cnt_ff == CNT_W'(SEG_BYTES - 1)) begin
                  cmd.seg_advance = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== verif/mono_framebuffer_serial_refresh_tb.sv =====
module mono_framebuffer_serial_refresh_tb;
   import mfsr_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 60;
   localparam int CHUNK_ITEMS   = 60;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [COL_W-1:0]  col;
      logic [ROWF_W-1:0] row;
   } req_item_type;

   typedef struct {
      logic [7:0] spi_byte;
      logic       transfer_end;
      logic       last;
   } spi_rec_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   mfsr_req_if req_ch ();
   mfsr_rsp_if rsp_ch ();

   mono_framebuffer_serial_refresh DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // framebuffer mirror and its settings
   logic [7:0]        frame_bytes [0:FRAME_BYTES-1];
   logic [SEG_W-1:0]  segment_ptr;
   logic [COL_W-1:0]  cur_max_column;
   logic [ROWF_W-1:0] cur_max_row;

   req_item_type pending_items [$];
   spi_rec_type  expected_spi_bytes [$];

   int  items_queued;
   int  items_accepted;
   int  fail_count;
   int  cycle_count;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  req_taken;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic push_spi_byte(logic [7:0] b, logic te, logic ls);
      spi_rec_type r;
      r.spi_byte     = b;
      r.transfer_end = te;
      r.last         = ls;
      expected_spi_bytes.push_back(r);
   endtask

   task automatic push_lcd_command(logic [7:0] d);
      push_spi_byte(START_CMD, 1'b0, 1'b0);
      push_spi_byte(d & NIBBLE_MASK, 1'b0, 1'b0);
      push_spi_byte(d << 4, 1'b1, 1'b0);
   endtask

   task automatic track_framebuffer_item(req_item_type it);
      logic [4:0]         ry;
      logic               half;
      logic [ROW_W-1:0]   src_row;
      logic [7:0]         b;
      logic [9:0]         idx;
      if (it.func == FUNC_SET_PIXEL) begin
         if (it.col <= cur_max_column && it.row <= cur_max_row) begin
            idx = {it.row, it.col[6:3]};
            frame_bytes[idx][3'd7 - it.col[2:0]] = 1'b1;
         end
      end else if (it.func == FUNC_CLEAR) begin
         for (int i = 0; i < FRAME_BYTES; i++) frame_bytes[i] = 8'h00;
      end else if (it.func == FUNC_REFRESH) begin
         ry      = segment_ptr[5:1];
         half    = segment_ptr[0];
         src_row = {half, ry};
         push_lcd_command(ADDR_FLAG | {3'b000, ry});
         push_lcd_command(ADDR_FLAG | (half ? 8'd8 : 8'd0));
         push_spi_byte(START_DATA, 1'b0, 1'b0);
         for (int i = 0; i < ROW_BYTES; i++) begin
            b = frame_bytes[src_row * ROW_BYTES + i];
            push_spi_byte(b & NIBBLE_MASK, 1'b0, 1'b0);
            push_spi_byte(b << 4, i == ROW_BYTES - 1, i == ROW_BYTES - 1);
         end
         segment_ptr = segment_ptr + 1'b1;
      end
   endtask

   task automatic queue_item(logic [FUNC_W-1:0] f, int c, int r);
      req_item_type it;
      it.func = f;
      it.col  = c[COL_W-1:0];
      it.row  = r[ROWF_W-1:0];
      pending_items.push_back(it);
      items_queued++;
   endtask

   function automatic int near_limit(int lim, int top);
      int v;
      v = lim + $urandom_range(2) - 1;
      if (v < 0) v = 0;
      if (v > top) v = top;
      return v;
   endfunction

   task automatic queue_random_item();
      int sel;
      int c;
      int r;
      sel = $urandom_range(99);
      c   = $urandom_range(127);
      r   = $urandom_range(63);
      if (sel < 56) begin
         if ($urandom_range(1)) begin
            c = near_limit(cur_max_column, 127);
            r = near_limit(cur_max_row, 63);
         end else if ($urandom_range(3) == 0) begin
            c = $urandom_range(cur_max_column);
            r = $urandom_range(cur_max_row);
         end
         queue_item(FUNC_SET_PIXEL, c, r);
      end else if (sel < 92) begin
         queue_item(FUNC_REFRESH, c, r);
      end else if (sel < 95) begin
         queue_item(FUNC_CLEAR, c, r);
      end else begin
         queue_item(FUNC_UNUSED, c, r);
      end
   endtask

   // hold until every transfer is done, then let any pixel or clear work finish
   task automatic wait_drained();
      do @(posedge clock);
      while (items_accepted != items_queued || expected_spi_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, int val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_W-1:0];
      if (idx == CSR_MAX_COLUMN) cur_max_column = val[COL_W-1:0];
      else cur_max_row = val[ROWF_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_limits(int mc, int mr);
      wait_drained();
      write_csr(CSR_MAX_COLUMN, mc);
      write_csr(CSR_MAX_ROW, mr);
   endtask

   // request driver
   always @(negedge clock) begin : req_driver
      req_item_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pending_items.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.func  <= nxt.func;
            req_ch.col   <= nxt.col;
            req_ch.row   <= nxt.row;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor: predict on each request transfer, check each response transfer
   always @(posedge clock) begin : monitor
      req_item_type it;
      spi_rec_type  want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_spi_bytes.size() == 0) begin
               $error("unexpected transfer: spi_byte %02h transfer_end %0b last %0b",
                      rsp_ch.spi_byte, rsp_ch.transfer_end, rsp_ch.last);
               fail_count++;
            end else begin
               want = expected_spi_bytes.pop_front();
               if (rsp_ch.spi_byte !== want.spi_byte) begin
                  $error("spi_byte: expected %02h, got %02h", want.spi_byte, rsp_ch.spi_byte);
                  fail_count++;
               end
               if (rsp_ch.transfer_end !== want.transfer_end) begin
                  $error("transfer_end: expected %0b, got %0b",
                         want.transfer_end, rsp_ch.transfer_end);
                  fail_count++;
               end
               if (rsp_ch.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
                  fail_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            it.func = req_ch.func;
            it.col  = req_ch.col;
            it.row  = req_ch.row;
            track_framebuffer_item(it);
            items_accepted++;
            req_taken = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int limits [8][2];
      int idle_modes [4][2];
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.func    = '0;
      req_ch.col     = '0;
      req_ch.row     = '0;
      rsp_ch.ready   = 1'b0;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      for (int i = 0; i < FRAME_BYTES; i++) frame_bytes[i] = 8'h00;
      segment_ptr    = '0;
      cur_max_column = 7'd127;
      cur_max_row    = 6'd63;
      items_queued   = 0;
      items_accepted = 0;
      fail_count     = 0;
      cycle_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: store corners, byte boundaries, both halves, unused selector
      set_limits(127, 63);
      queue_item(FUNC_SET_PIXEL, 0, 0);
      queue_item(FUNC_SET_PIXEL, 127, 63);
      queue_item(FUNC_SET_PIXEL, 7, 0);
      queue_item(FUNC_SET_PIXEL, 8, 0);
      queue_item(FUNC_SET_PIXEL, 127, 0);
      queue_item(FUNC_SET_PIXEL, 0, 32);
      queue_item(FUNC_SET_PIXEL, 65, 33);
      queue_item(FUNC_UNUSED, 127, 63);
      queue_item(FUNC_REFRESH, 0, 0);
      queue_item(FUNC_REFRESH, 127, 63);
      queue_item(FUNC_REFRESH, 0, 0);
      queue_item(FUNC_REFRESH, 0, 0);
      queue_item(FUNC_CLEAR, 0, 0);
      queue_item(FUNC_REFRESH, 0, 0);

      // out-of-range pixels
      set_limits(0, 0);
      queue_item(FUNC_SET_PIXEL, 1, 0);
      queue_item(FUNC_SET_PIXEL, 0, 1);
      queue_item(FUNC_SET_PIXEL, 127, 63);
      queue_item(FUNC_SET_PIXEL, 0, 0);
      set_limits(10, 5);
      queue_item(FUNC_SET_PIXEL, 10, 5);
      queue_item(FUNC_SET_PIXEL, 11, 5);
      queue_item(FUNC_SET_PIXEL, 10, 6);
      queue_item(FUNC_REFRESH, 0, 0);
      queue_item(FUNC_REFRESH, 0, 0);

      limits = '{'{127, 63}, '{0, 0}, '{100, 40}, '{-1, -1},
                 '{127, 63}, '{63, 31}, '{-1, -1}, '{127, 63}};
      idle_modes = '{'{0, 0}, '{88, 0}, '{0, 88}, '{14, 14}};

      for (int ph = 0; ph < 8; ph++) begin
         if (limits[ph][0] < 0) set_limits($urandom_range(127), $urandom_range(63));
         else set_limits(limits[ph][0], limits[ph][1]);
         send_idle_pct  = idle_modes[ph % 4][0];
         recv_stall_pct = idle_modes[ph % 4][1];
         for (int n = 0; n < CHUNK_ITEMS; n++) queue_random_item();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
